/* rtl/core/irs_pkg.sv */
`default_nettype none

package irs_pkg;

    // parameter defaults
    localparam int NUM_SENSORS_DEF = 3;
    localparam int AVG_DEPTH_DEF   = 4;
    localparam int ADC_BITS_DEF    = 12;

    // fixed field widths
    localparam int TIME_W     = 32;
    localparam int SETTLE_W   = 16;
    localparam int NUMER_W    = 16;
    localparam int OFFSET_W   = 12;
    localparam int DIST_W     = 16;
    localparam int IDX_W      = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int FRAC_BITS  = 8;
    localparam int QUOT_W     = NUMER_W + FRAC_BITS;

    // register reset values
    localparam logic [SETTLE_W-1:0] SETTLE_RST = 16'd5;
    localparam logic [NUMER_W-1:0]  NUMER_RST  = 16'd4800;
    localparam logic [OFFSET_W-1:0] OFFSET_RST = 12'd20;

    localparam logic [DIST_W-1:0] DIST_MAX = '1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SETTLE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NUMER  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET = 2'd2;

    typedef enum logic [1:0] {
        PH_ENABLE = 2'd0,
        PH_WAIT   = 2'd1,
        PH_READ   = 2'd2
    } t_phase;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REC,
        ST_DIST,
        ST_AVG,
        ST_OUT
    } t_state;

endpackage

`default_nettype wire

/* rtl/core/irs_in_if.sv */
`default_nettype none

interface irs_in_if #(
    parameter int ADC_BITS = irs_pkg::ADC_BITS_DEF
);
    logic                        valid;
    logic                        ready;
    logic [irs_pkg::TIME_W-1:0]  now_ms;
    logic [ADC_BITS-1:0]         adc_sample;

    modport source (output valid, output now_ms, output adc_sample, input ready);
    modport sink   (input valid, input now_ms, input adc_sample, output ready);
endinterface

`default_nettype wire

/* rtl/core/irs_out_if.sv */
`default_nettype none

interface irs_out_if #(
    parameter int NUM_SENSORS = irs_pkg::NUM_SENSORS_DEF,
    parameter int ADC_BITS    = irs_pkg::ADC_BITS_DEF
);
    logic                        valid;
    logic                        ready;
    logic [NUM_SENSORS-1:0]      emitter_mask;
    logic                        reading_valid;
    logic [irs_pkg::IDX_W-1:0]   sensor_index;
    logic [ADC_BITS-1:0]         raw_sample;
    logic [irs_pkg::DIST_W-1:0]  distance_avg;

    modport source (
        output valid, output emitter_mask, output reading_valid,
        output sensor_index, output raw_sample, output distance_avg,
        input ready
    );
    modport sink (
        input valid, input emitter_mask, input reading_valid,
        input sensor_index, input raw_sample, input distance_avg,
        output ready
    );
endinterface

`default_nettype wire

/* rtl/core/ir_range_sensor_sequencer.sv */
// Enable and wait steps: result word set at accept, moved to the output register once that
// register is free. Read step: record and history read, radix-2 distance divider (one
// quotient bit per cycle), then the ring average, a reciprocal multiply of the registered
// sum. One word in flight; the next word is taken once the result is in the output register.
// Synchronous active-low reset: scan to enable phase / front sensor, registers to
// defaults, history and ring sums read as zero (valid bits, no clearing pass).
`default_nettype none

module ir_range_sensor_sequencer #(
    parameter int NUM_SENSORS = irs_pkg::NUM_SENSORS_DEF,
    parameter int AVG_DEPTH   = irs_pkg::AVG_DEPTH_DEF,
    parameter int ADC_BITS    = irs_pkg::ADC_BITS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    irs_in_if.sink                               i_in,
    irs_out_if.source                            o_out,
    input  wire logic                            i_cfg_we,
    input  wire logic [irs_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [irs_pkg::CFG_DATA_W-1:0]  i_cfg_wdata
);

    localparam int SIDX_W  = (NUM_SENSORS > 1) ? $clog2(NUM_SENSORS) : 1;
    localparam int SLOT_W  = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
    localparam int SUM_W   = irs_pkg::DIST_W + $clog2(AVG_DEPTH);
    localparam int REC_W   = SLOT_W + SUM_W;
    localparam int HIST_D  = NUM_SENSORS * AVG_DEPTH;
    localparam int HA_W    = (HIST_D > 1) ? $clog2(HIST_D) : 1;
    localparam int DIVR_W  = ((ADC_BITS > irs_pkg::OFFSET_W) ? ADC_BITS
                                                             : irs_pkg::OFFSET_W) + 1;
    localparam int QUOT_W  = irs_pkg::QUOT_W;
    localparam int DIST_W  = irs_pkg::DIST_W;
    // ring average: floor(sum / AVG_DEPTH) as (sum * ceil(2^AVG_SH / AVG_DEPTH)) >> AVG_SH,
    // exact over the whole sum range
    localparam int AVG_SH  = SUM_W + $clog2(AVG_DEPTH);
    localparam int RECIP_W = SUM_W + 1;
    localparam int PROD_W  = SUM_W + RECIP_W;
    localparam logic [RECIP_W-1:0] AVG_RECIP =
        RECIP_W'(((64'd1 << AVG_SH) + 64'(AVG_DEPTH) - 64'd1) / 64'(AVG_DEPTH));

    // ---------------- configuration registers ----------------
    logic [irs_pkg::SETTLE_W-1:0] r_settle;
    logic [irs_pkg::NUMER_W-1:0]  r_numer;
    logic [irs_pkg::OFFSET_W-1:0] r_offset;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_settle <= irs_pkg::SETTLE_RST;
            r_numer  <= irs_pkg::NUMER_RST;
            r_offset <= irs_pkg::OFFSET_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                irs_pkg::CFG_SETTLE: r_settle <= i_cfg_wdata;
                irs_pkg::CFG_NUMER:  r_numer  <= i_cfg_wdata;
                irs_pkg::CFG_OFFSET: r_offset <= i_cfg_wdata[irs_pkg::OFFSET_W-1:0];
                default: ;  // unmapped index: ignored
            endcase
        end
    end

    // ---------------- scan state ----------------
    irs_pkg::t_state              r_state, n_state;
    irs_pkg::t_phase              r_phase;
    logic [SIDX_W-1:0]            r_active;
    logic [irs_pkg::TIME_W-1:0]   r_enable_time;
    logic [ADC_BITS-1:0]          r_sample;
    logic [SUM_W-1:0]             r_avg_sum;

    // pending result word
    logic [NUM_SENSORS-1:0]       r_res_mask;
    logic                         r_res_valid;
    logic [ADC_BITS-1:0]          r_res_raw;
    logic [DIST_W-1:0]            r_res_avg;

    // output register
    logic                         r_out_valid;
    logic [NUM_SENSORS-1:0]       r_out_mask;
    logic                         r_out_rvalid;
    logic [irs_pkg::IDX_W-1:0]    r_out_idx;
    logic [ADC_BITS-1:0]          r_out_raw;
    logic [DIST_W-1:0]            r_out_avg;
    logic [irs_pkg::IDX_W-1:0]    r_res_idx;

    // control strobes
    logic w_in_ready, w_accept, w_rec_re, w_hist_re, w_div_start;
    logic w_dist_done, w_avg_done, w_out_free, w_out_load;

    // datapath
    logic                         w_div_done;
    logic [QUOT_W-1:0]            w_quot;
    logic [QUOT_W-1:0]            w_div_dividend;
    logic [DIVR_W-1:0]            w_div_divisor;
    logic [REC_W-1:0]             w_rec_rdata;
    logic [SLOT_W-1:0]            w_rec_slot;
    logic [SUM_W-1:0]             w_rec_sum;
    logic [DIST_W-1:0]            w_hist_old;
    logic [HA_W-1:0]              w_hist_addr;
    logic [DIST_W-1:0]            w_dist;
    logic [SUM_W-1:0]             w_new_sum;
    logic [SLOT_W-1:0]            w_next_slot;
    logic [SIDX_W-1:0]            w_active_next;
    logic [NUM_SENSORS-1:0]       w_onehot;
    logic [irs_pkg::TIME_W-1:0]   w_elapsed;
    logic                         w_settled;
    logic [PROD_W-1:0]            w_avg_prod;

    assign w_out_free = !r_out_valid || o_out.ready;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            irs_pkg::ST_IDLE: begin
                if (i_in.valid) begin
                    n_state = (r_phase == irs_pkg::PH_READ) ? irs_pkg::ST_REC
                                                            : irs_pkg::ST_OUT;
                end
            end
            irs_pkg::ST_REC:  n_state = irs_pkg::ST_DIST;
            irs_pkg::ST_DIST: begin
                if (w_div_done) begin
                    n_state = irs_pkg::ST_AVG;
                end
            end
            irs_pkg::ST_AVG:  n_state = irs_pkg::ST_OUT;
            irs_pkg::ST_OUT: begin
                if (w_out_free) begin
                    n_state = irs_pkg::ST_IDLE;
                end
            end
            default: n_state = irs_pkg::ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        w_in_ready  = (r_state == irs_pkg::ST_IDLE);
        w_accept    = w_in_ready && i_in.valid;
        w_rec_re    = w_accept && (r_phase == irs_pkg::PH_READ);
        w_hist_re   = (r_state == irs_pkg::ST_REC);
        w_dist_done = (r_state == irs_pkg::ST_DIST) && w_div_done;
        w_avg_done  = (r_state == irs_pkg::ST_AVG);
        w_div_start = w_hist_re;
        w_out_load  = (r_state == irs_pkg::ST_OUT) && w_out_free;
    end

    assign i_in.ready = w_in_ready;

    // record layout: {slot, ring sum}
    assign w_rec_slot  = w_rec_rdata[REC_W-1 -: SLOT_W];
    assign w_rec_sum   = w_rec_rdata[SUM_W-1:0];
    assign w_hist_addr = HA_W'(r_active * AVG_DEPTH) + HA_W'(w_rec_slot);

    always_comb begin
        // Q16.8 quotient saturates to Q8.8; zero divisor gives all ones, hence the top value
        w_dist      = (|w_quot[QUOT_W-1:DIST_W]) ? irs_pkg::DIST_MAX : w_quot[DIST_W-1:0];
        // running ring sum: drop the overwritten entry, add the new one
        w_new_sum   = w_rec_sum - SUM_W'(w_hist_old) + SUM_W'(w_dist);
        w_next_slot = (w_rec_slot == SLOT_W'(AVG_DEPTH - 1)) ? '0
                                                             : w_rec_slot + SLOT_W'(1);
        w_active_next = (r_active == SIDX_W'(NUM_SENSORS - 1)) ? '0
                                                               : r_active + SIDX_W'(1);
        w_onehot    = NUM_SENSORS'(1) << r_active;
        w_elapsed   = i_in.now_ms - r_enable_time;  // wraps modulo 2^32
        w_settled   = (w_elapsed >= irs_pkg::TIME_W'(r_settle));
    end

    // distance divider operands
    assign w_div_dividend = {r_numer, {irs_pkg::FRAC_BITS{1'b0}}};
    assign w_div_divisor  = DIVR_W'(r_sample) + DIVR_W'(r_offset);

    // ring average from the registered sum
    assign w_avg_prod = PROD_W'(r_avg_sum) * PROD_W'(AVG_RECIP);

    irs_div #(
        .N_W (QUOT_W),
        .D_W (DIVR_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_dividend),
        .i_divisor  (w_div_divisor),
        .o_done     (w_div_done),
        .o_quot     (w_quot)
    );

    // Only one word is in flight, so a write always lands before the next read
    // of the same entry: no forwarding needed.
    irs_store #(
        .NUM_SENSORS (NUM_SENSORS),
        .AVG_DEPTH   (AVG_DEPTH),
        .REC_W       (REC_W),
        .SIDX_W      (SIDX_W),
        .HA_W        (HA_W)
    ) u_store (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_rec_re     (w_rec_re),
        .i_rec_raddr  (r_active),
        .o_rec_rdata  (w_rec_rdata),
        .i_rec_we     (w_dist_done),
        .i_rec_waddr  (r_active),
        .i_rec_wdata  ({w_next_slot, w_new_sum}),
        .i_hist_re    (w_hist_re),
        .i_hist_raddr (w_hist_addr),
        .o_hist_rdata (w_hist_old),
        .i_hist_we    (w_dist_done),
        .i_hist_waddr (w_hist_addr),
        .i_hist_wdata (w_dist)
    );

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= irs_pkg::ST_IDLE;
            r_phase       <= irs_pkg::PH_ENABLE;
            r_active      <= '0;
            r_enable_time <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_accept) begin
                unique case (r_phase)
                    irs_pkg::PH_WAIT: begin
                        if (w_settled) begin
                            r_phase <= irs_pkg::PH_READ;
                        end
                    end
                    irs_pkg::PH_READ: ;  // finishes at the average
                    default: begin      // enable: light emitter, latch time
                        r_enable_time <= i_in.now_ms;
                        r_phase       <= irs_pkg::PH_WAIT;
                    end
                endcase
            end
            if (w_avg_done) begin
                r_active <= w_active_next;
                r_phase  <= irs_pkg::PH_ENABLE;
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_sample    <= i_in.adc_sample;
            r_res_mask  <= w_onehot;  // enable and wait steps leave the emitter lit
            r_res_valid <= 1'b0;
            r_res_idx   <= irs_pkg::IDX_W'(r_active);
            r_res_raw   <= '0;
            r_res_avg   <= '0;
        end
        if (w_dist_done) begin
            r_avg_sum <= w_new_sum;
        end
        if (w_avg_done) begin
            r_res_mask  <= '0;
            r_res_valid <= 1'b1;
            r_res_raw   <= r_sample;
            r_res_avg   <= w_avg_prod[AVG_SH +: DIST_W];
        end
        if (w_out_load) begin
            r_out_mask   <= r_res_mask;
            r_out_rvalid <= r_res_valid;
            r_out_idx    <= r_res_idx;
            r_out_raw    <= r_res_raw;
            r_out_avg    <= r_res_avg;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.emitter_mask  = r_out_mask;
    assign o_out.reading_valid = r_out_rvalid;
    assign o_out.sensor_index  = r_out_idx;
    assign o_out.raw_sample    = r_out_raw;
    assign o_out.distance_avg  = r_out_avg;

    // ---------------- assertions ----------------
    // A finished read leaves the emitters dark and returns to the enable phase.
    a_read_ends_dark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_avg_done |=> (r_res_valid && (r_res_mask == '0) &&
                        (r_phase == irs_pkg::PH_ENABLE)))
        else $error("read step did not end dark in enable phase");

    // The scan advances to the next sensor exactly when a read completes.
    a_sensor_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_avg_done |=> (r_active == $past(w_active_next)))
        else $error("active sensor did not advance after read");

    // Only a read step produces a valid reading.
    a_no_reading_outside_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == irs_pkg::ST_OUT) && (r_phase != irs_pkg::PH_ENABLE)) |-> !r_res_valid)
        else $error("reading flagged on an enable or wait step");

endmodule

`default_nettype wire

/* rtl/core/irs_div.sv */
`default_nettype none

// Radix-2 restoring divider, one quotient bit per cycle.
// A zero divisor yields an all-ones quotient.
module irs_div #(
    parameter int N_W = irs_pkg::QUOT_W,
    parameter int D_W = irs_pkg::OFFSET_W + 1
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_start,
    input  wire logic [N_W-1:0] i_dividend,
    input  wire logic [D_W-1:0] i_divisor,
    output logic                o_done,
    output logic [N_W-1:0]      o_quot
);

    localparam int CNT_W = $clog2(N_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [N_W-1:0]   r_quot;
    logic [D_W-1:0]   r_rem;
    logic [D_W-1:0]   r_divisor;

    logic [D_W:0]     w_shift;
    logic [D_W:0]     w_diff;
    logic             w_ge;
    logic [D_W-1:0]   n_rem;

    always_comb begin
        w_shift = {r_rem, r_quot[N_W-1]};
        w_diff  = w_shift - {1'b0, r_divisor};
        w_ge    = (w_shift >= {1'b0, r_divisor});
        n_rem   = w_ge ? w_diff[D_W-1:0] : w_shift[D_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= CNT_W'(N_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quot    <= i_dividend;
            r_rem     <= '0;
            r_divisor <= i_divisor;
        end else if (r_busy) begin
            r_quot <= {r_quot[N_W-2:0], w_ge};
            r_rem  <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

`default_nettype wire

/* rtl/core/irs_store.sv */
`default_nettype none

// Per-sensor record memory {slot, ring sum} and distance history memory.
// Valid bits make never-written entries read as zero after reset.
module irs_store #(
    parameter int NUM_SENSORS = irs_pkg::NUM_SENSORS_DEF,
    parameter int AVG_DEPTH   = irs_pkg::AVG_DEPTH_DEF,
    parameter int REC_W       = irs_pkg::DIST_W + 3,
    parameter int SIDX_W      = (NUM_SENSORS > 1) ? $clog2(NUM_SENSORS) : 1,
    parameter int HA_W        = (NUM_SENSORS * AVG_DEPTH > 1) ?
                                $clog2(NUM_SENSORS * AVG_DEPTH) : 1
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_rec_re,
    input  wire logic [SIDX_W-1:0]           i_rec_raddr,
    output logic [REC_W-1:0]                 o_rec_rdata,
    input  wire logic                        i_rec_we,
    input  wire logic [SIDX_W-1:0]           i_rec_waddr,
    input  wire logic [REC_W-1:0]            i_rec_wdata,
    input  wire logic                        i_hist_re,
    input  wire logic [HA_W-1:0]             i_hist_raddr,
    output logic [irs_pkg::DIST_W-1:0]       o_hist_rdata,
    input  wire logic                        i_hist_we,
    input  wire logic [HA_W-1:0]             i_hist_waddr,
    input  wire logic [irs_pkg::DIST_W-1:0]  i_hist_wdata
);

    localparam int HIST_D = NUM_SENSORS * AVG_DEPTH;

    logic [REC_W-1:0]           r_rec_mem  [NUM_SENSORS];
    logic [NUM_SENSORS-1:0]     r_rec_vld;
    logic [REC_W-1:0]           r_rec_rdata;
    logic [irs_pkg::DIST_W-1:0] r_hist_mem [HIST_D];
    logic [HIST_D-1:0]          r_hist_vld;
    logic [irs_pkg::DIST_W-1:0] r_hist_rdata;

    always_ff @(posedge i_clk) begin
        if (i_rec_we) begin
            r_rec_mem[i_rec_waddr] <= i_rec_wdata;
        end
        if (i_rec_re) begin
            r_rec_rdata <= r_rec_vld[i_rec_raddr] ? r_rec_mem[i_rec_raddr] : '0;
        end
        if (i_hist_we) begin
            r_hist_mem[i_hist_waddr] <= i_hist_wdata;
        end
        if (i_hist_re) begin
            r_hist_rdata <= r_hist_vld[i_hist_raddr] ? r_hist_mem[i_hist_raddr] : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rec_vld  <= '0;
            r_hist_vld <= '0;
        end else begin
            if (i_rec_we) begin
                r_rec_vld[i_rec_waddr] <= 1'b1;
            end
            if (i_hist_we) begin
                r_hist_vld[i_hist_waddr] <= 1'b1;
            end
        end
    end

    assign o_rec_rdata  = r_rec_rdata;
    assign o_hist_rdata = r_hist_rdata;

endmodule

`default_nettype wire

/* verif/tb.sv */
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_SENS  = irs_pkg::NUM_SENSORS_DEF;
    localparam int RING_D  = irs_pkg::AVG_DEPTH_DEF;
    localparam int ADC_W   = irs_pkg::ADC_BITS_DEF;
    localparam int HOLD_CYCLES = 300;   // long receiver hold-off, fills the block
    localparam int DRAIN_CYCLES = 60;   // drain margin, over one read step

    // One result word as the sink sees it.
    typedef struct packed {
        logic [N_SENS-1:0]          mask;
        logic                       rv;
        logic [irs_pkg::IDX_W-1:0]  idx;
        logic [ADC_W-1:0]           raw;
        logic [irs_pkg::DIST_W-1:0] avg;
    } t_scan_word;

    // Tracks the scan state and the distance rings; keeps the words still owed
    // by the block and checks each delivered word against the oldest of them.
    class t_scan_tracker;
        logic [irs_pkg::SETTLE_W-1:0] settle;
        logic [irs_pkg::NUMER_W-1:0]  numer;
        logic [irs_pkg::OFFSET_W-1:0] offset;
        irs_pkg::t_phase              phase;
        logic [irs_pkg::IDX_W-1:0]    sensor;
        logic [irs_pkg::TIME_W-1:0]   lit_time;
        logic [irs_pkg::DIST_W-1:0]   ring [N_SENS][RING_D];
        int unsigned                  ring_pos [N_SENS];
        t_scan_word                   owed_words [$];
        int unsigned                  errors;
        int unsigned                  readings;

        function new();
            settle   = irs_pkg::SETTLE_RST;
            numer    = irs_pkg::NUMER_RST;
            offset   = irs_pkg::OFFSET_RST;
            phase    = irs_pkg::PH_ENABLE;
            sensor   = '0;
            lit_time = '0;
            errors   = 0;
            readings = 0;
            for (int s = 0; s < N_SENS; s++) begin
                ring_pos[s] = 0;
                for (int k = 0; k < RING_D; k++) ring[s][k] = '0;
            end
        endfunction

        function void set_regs(logic [irs_pkg::SETTLE_W-1:0] s,
                               logic [irs_pkg::NUMER_W-1:0] n,
                               logic [irs_pkg::OFFSET_W-1:0] o);
            settle = s;
            numer  = n;
            offset = o;
        endfunction

        // Q8.8 distance, truncated, saturated; a zero divisor saturates too.
        function logic [irs_pkg::DIST_W-1:0] to_cm(logic [ADC_W-1:0] smp);
            logic [irs_pkg::OFFSET_W:0] div;
            logic [irs_pkg::QUOT_W-1:0] q;
            div = {1'b0, smp} + {1'b0, offset};
            if (div == '0) return irs_pkg::DIST_MAX;
            q = {numer, 8'h00} / irs_pkg::QUOT_W'(div);
            return (q > irs_pkg::QUOT_W'(irs_pkg::DIST_MAX)) ? irs_pkg::DIST_MAX
                                                             : q[irs_pkg::DIST_W-1:0];
        endfunction

        function void note_update(logic [irs_pkg::TIME_W-1:0] now, logic [ADC_W-1:0] smp);
            t_scan_word                 w;
            logic [irs_pkg::TIME_W-1:0] gap;
            logic [17:0]                sum;
            int unsigned                s;
            w   = '0;
            s   = sensor % N_SENS;
            gap = now - lit_time;   // wrapping difference
            sum = '0;
            w.idx = irs_pkg::IDX_W'(s);
            case (phase)
                irs_pkg::PH_WAIT: begin
                    if (gap >= irs_pkg::TIME_W'(settle)) phase = irs_pkg::PH_READ;
                end
                irs_pkg::PH_READ: begin
                    w.rv  = 1'b1;
                    w.raw = smp;
                    ring[s][ring_pos[s]] = to_cm(smp);
                    ring_pos[s] = (ring_pos[s] + 1) % RING_D;
                    for (int k = 0; k < RING_D; k++) sum += ring[s][k];
                    w.avg  = irs_pkg::DIST_W'(sum / RING_D);
                    sensor = irs_pkg::IDX_W'((s + 1) % N_SENS);
                    phase  = irs_pkg::PH_ENABLE;
                    readings++;
                end
                default: begin   // enable, and the unused code 3
                    lit_time = now;
                    phase    = irs_pkg::PH_WAIT;
                end
            endcase
            w.mask = (phase == irs_pkg::PH_ENABLE) ? '0 : N_SENS'(1) << sensor;
            owed_words.push_back(w);
        endfunction

        task report(string msg);
            $display("[%0t] mismatch: %s", $realtime, msg);
            errors++;
        endtask

        task check_word(t_scan_word got);
            t_scan_word want;
            if (owed_words.size() == 0) begin
                report($sformatf("word %h delivered with nothing owed", got));
                return;
            end
            want = owed_words.pop_front();
            if (got.mask !== want.mask)
                report($sformatf("emitter_mask %b, want %b", got.mask, want.mask));
            if (got.rv !== want.rv)
                report($sformatf("reading_valid %b, want %b", got.rv, want.rv));
            if (got.idx !== want.idx)
                report($sformatf("sensor_index %0d, want %0d", got.idx, want.idx));
            if (got.raw !== want.raw)
                report($sformatf("raw_sample %h, want %h", got.raw, want.raw));
            if (got.avg !== want.avg)
                report($sformatf("distance_avg %h, want %h", got.avg, want.avg));
        endtask

        function int unsigned pending();
            return owed_words.size();
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_we;
    logic [irs_pkg::CFG_IDX_W-1:0]  i_cfg_idx;
    logic [irs_pkg::CFG_DATA_W-1:0] i_cfg_wdata;

    irs_in_if  #(.ADC_BITS(ADC_W)) in_if ();
    irs_out_if #(.NUM_SENSORS(N_SENS), .ADC_BITS(ADC_W)) out_if ();

    ir_range_sensor_sequencer #(
        .NUM_SENSORS(N_SENS),
        .AVG_DEPTH  (RING_D),
        .ADC_BITS   (ADC_W)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_if),
        .o_out      (out_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_wdata(i_cfg_wdata)
    );

    t_scan_tracker              sb;
    bit                         rst_done  = 1'b0;
    bit                         idle_on   = 1'b1;   // random bursts on both sides
    bit                         hold_req  = 1'b0;   // asks the sink for one long hold-off
    int unsigned                words_sent = 0;
    int unsigned                settings   = 1;     // reset values count as the first
    logic [irs_pkg::TIME_W-1:0] ms_clock;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Safety net: far above the slowest legal run (~1.2k words plus stalls).
    initial begin
        #5ms;
        $display("timeout: %0d words still owed", sb.pending());
        $display("*** FAILED ***");
        $finish;
    end

    // Result sink. Samples at the edge (pre-NBA values), then picks next ready.
    initial begin : sink_side
        int unsigned stall_left;
        t_scan_word  got;
        stall_left = 0;
        out_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (rst_done && out_if.valid && out_if.ready) begin
                got.mask = out_if.emitter_mask;
                got.rv   = out_if.reading_valid;
                got.idx  = out_if.sensor_index;
                got.raw  = out_if.raw_sample;
                got.avg  = out_if.distance_avg;
                sb.check_word(got);
            end
            if (stall_left > 0) begin
                stall_left--;
                out_if.ready <= 1'b0;
            end else if (hold_req) begin
                // long hold-off; the source keeps offering words meanwhile
                hold_req = 1'b0;
                stall_left = HOLD_CYCLES - 1;
                out_if.ready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 4) == 0) begin
                stall_left = $urandom_range(1, 4) - 1;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= 1'b1;
            end
        end
    end

    // Offer one update word; returns at the edge where it was taken.
    // A word that follows at once keeps valid high with a single assignment.
    task automatic send_update(logic [irs_pkg::TIME_W-1:0] now, logic [ADC_W-1:0] smp);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            in_if.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        in_if.valid      <= 1'b1;
        in_if.now_ms     <= now;
        in_if.adc_sample <= smp;
        do @(posedge i_clk); while (!in_if.ready);
        sb.note_update(now, smp);
        words_sent++;
    endtask

    // Registers change only with nothing in flight. Every item makes a word,
    // so an empty list of owed words means the block is idle.
    task automatic program_regs(logic [irs_pkg::SETTLE_W-1:0] s,
                                logic [irs_pkg::NUMER_W-1:0] n,
                                logic [irs_pkg::OFFSET_W-1:0] o);
        in_if.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= irs_pkg::CFG_SETTLE;
        i_cfg_wdata <= s;
        @(posedge i_clk);
        i_cfg_idx   <= irs_pkg::CFG_NUMER;
        i_cfg_wdata <= n;
        @(posedge i_clk);
        i_cfg_idx   <= irs_pkg::CFG_OFFSET;
        i_cfg_wdata <= irs_pkg::CFG_DATA_W'(o);
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        sb.set_regs(s, n, o);
        settings++;
    endtask

    // Mostly steady time with small steps so scans complete; some jumps near the
    // settle time, some random time jumps and some backward steps as noise.
    task automatic run_random(int unsigned n, bit with_hold);
        int unsigned       r;
        logic [ADC_W-1:0]  smp;
        ms_clock = $urandom();
        for (int unsigned k = 0; k < n; k++) begin
            r = $urandom_range(0, 99);
            if (r < 60)      ms_clock += $urandom_range(0, 3);
            else if (r < 85) ms_clock += $urandom_range(0, 2 * sb.settle + 1);
            else if (r < 93) ms_clock = $urandom();
            else             ms_clock -= $urandom_range(1, 8);
            r = $urandom_range(0, 99);
            if (r < 8)       smp = '0;
            else if (r < 16) smp = '1;
            else             smp = ADC_W'($urandom_range(0, (1 << ADC_W) - 1));
            if (with_hold && k == n / 4) hold_req = 1'b1;
            send_update(ms_clock, smp);
        end
    endtask

    initial begin : stimulus
        in_if.valid      <= 1'b0;
        in_if.now_ms     <= '0;
        in_if.adc_sample <= '0;
        i_cfg_we         <= 1'b0;
        i_cfg_idx        <= irs_pkg::CFG_SETTLE;
        i_cfg_wdata      <= '0;
        i_rst_n          <= 1'b0;
        sb = new();
        repeat (4) @(posedge i_clk);
        i_rst_n  <= 1'b1;
        rst_done = 1'b1;

        // Reset values: settle 5, wait across the 2^32 wrap.
        send_update(32'hFFFF_FFFC, 12'hABC);   // enable; sample ignored
        send_update(32'hFFFF_FFFF, 12'hFFF);   // 3 ms, still waiting
        send_update(32'h0000_0001, 12'h000);   // 5 ms across the wrap, move to read
        send_update(32'h0000_0001, 12'h000);   // read: sample 0
        // left sensor: time running backward reads as a huge wrapped gap
        send_update(32'h8000_0000, 12'h000);
        send_update(32'h8000_0004, 12'h000);   // 4 ms, short
        send_update(32'h7FFF_FFFF, 12'h000);   // wraps to 0xFFFFFFFF, passes
        send_update(32'h7FFF_FFFF, 12'hFFF);   // read: full-scale sample
        // right sensor
        send_update(32'h5555_5555, 12'h000);
        send_update(32'h5555_555A, 12'h000);
        send_update(32'hAAAA_AAAA, 12'h555);

        // Zero settle passes at once; numerator max over offset 1 saturates.
        program_regs(16'd0, 16'hFFFF, 12'd1);
        send_update(32'h0000_0000, 12'h000);
        send_update(32'h0000_0000, 12'h000);
        send_update(32'h0000_0000, 12'h000);

        // Zero offset with a zero sample: zero divisor saturates.
        program_regs(16'd0, 16'hFFFF, 12'd0);
        send_update(32'h1234_5678, 12'h000);
        send_update(32'h1234_5678, 12'h000);
        send_update(32'h1234_5678, 12'h000);

        // Longest settle, smallest numerator, largest offset: distance 0.
        program_regs(16'hFFFF, 16'd1, 12'hFFF);
        send_update(32'h0000_0000, 12'h000);
        send_update(32'h0000_FFFE, 12'h000);   // one ms short
        send_update(32'h0000_FFFF, 12'h000);   // exactly the settle time
        send_update(32'h0001_0000, 12'hFFF);   // read

        // Random phases across register settings, extremes included.
        program_regs(irs_pkg::SETTLE_RST, irs_pkg::NUMER_RST, irs_pkg::OFFSET_RST);
        run_random(200, 1'b0);
        program_regs(16'd0, 16'hFFFF, 12'd1);
        run_random(200, 1'b1);
        program_regs(16'hFFFF, 16'd1, 12'hFFF);
        run_random(200, 1'b0);
        program_regs(irs_pkg::SETTLE_W'($urandom_range(1, 20)),
                     irs_pkg::NUMER_W'($urandom_range(1, 65535)),
                     irs_pkg::OFFSET_W'($urandom_range(1, 4095)));
        run_random(200, 1'b0);
        program_regs(irs_pkg::SETTLE_W'($urandom()), irs_pkg::NUMER_W'($urandom()),
                     irs_pkg::OFFSET_W'($urandom()));
        run_random(200, 1'b0);
        // last stretch at full rate on both sides
        program_regs(16'd3, irs_pkg::NUMER_W'($urandom_range(1, 65535)),
                     irs_pkg::OFFSET_W'($urandom_range(0, 4095)));
        idle_on = 1'b0;
        run_random(200, 1'b0);
        in_if.valid <= 1'b0;

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.pending() != 0) sb.report($sformatf("%0d words never arrived", sb.pending()));

        $display("Run covered %0d update words (%0d sensor readings) over %0d register",
                 words_sent, sb.readings, settings);
        $display("settings incl. zero/max settle, zero offset and saturating distances.");
        if (sb.errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

`default_nettype wire

/* ir_range_sensor_sequencer.f */
rtl/core/irs_pkg.sv
rtl/core/irs_in_if.sv
rtl/core/irs_out_if.sv
rtl/core/irs_div.sv
rtl/core/irs_store.sv
rtl/core/ir_range_sensor_sequencer.sv
verif/tb.sv
